@@ design/nfa_pkg.sv @@
package nfa_pkg;

    // heap geometry
    localparam int HEAP_SIZE = 1024;
    localparam int ADDR_W    = $clog2(HEAP_SIZE);
    localparam int LEN_W     = $clog2(HEAP_SIZE + 1);

    // item field widths
    localparam int SIZE_W   = 11;
    localparam int OFF_W    = 10;
    localparam int STATUS_W = 2;

    // common width for comparing a segment length against a request size
    localparam int CMP_W = (LEN_W > SIZE_W) ? LEN_W : SIZE_W;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(HEAP_SIZE - 1);

    // opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOFIT   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZERO    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BADFREE = 2'd3;

    typedef struct packed {
        logic              opcode;
        logic [SIZE_W-1:0] request_size;
        logic [OFF_W-1:0]  free_offset;
    } cmd_t;

    typedef struct packed {
        logic [OFF_W-1:0]    block_offset;
        logic [STATUS_W-1:0] status;
    } result_t;

    // one heap unit as held in the segment map
    typedef struct packed {
        logic start_mark;
        logic alloc_mark;
    } unit_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        unit_t             data;
    } ram_wr_t;

    typedef struct packed {
        logic    valid;
        result_t res;
    } rsp_t;

endpackage

@@ design/next_fit_heap_allocator.sv @@
// channel   direction  handshake                     payload
// command   in         start high, busy low at edge  cmd    (opcode, request_size, free_offset)
// result    out        done high for one cycle       result (block_offset, status)
//
// zero size and out-of-range free offset: result registered in the cycle after the item is taken
// free at a unit that is not a segment start: result from the free check state, then registered
// allocate: one heap unit read per cycle from the segment map
// free: a full merge sweep over the segment map port
// after reset a clearing pass over the segment map holds busy high
// the receiver cannot stall; busy is the only back-pressure on the command side
module next_fit_heap_allocator (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  nfa_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done,
    output nfa_pkg::result_t result
);

    // segment map port signals
    logic [nfa_pkg::ADDR_W-1:0] rd_addr;
    nfa_pkg::unit_t             rd_data;
    nfa_pkg::ram_wr_t           wr;

    // completion from the sequencer, registered onto the result ports
    nfa_pkg::rsp_t    rsp;
    logic             done_reg;
    nfa_pkg::result_t result_reg;

    nfa_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .busy    (busy),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr),
        .rsp     (rsp)
    );

    nfa_seg_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // strobe is control, cleared on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= rsp.valid;
        end
    end

    // result payload, only meaningful with the strobe
    always_ff @(posedge clk)
    begin
        if (rsp.valid)
        begin
            result_reg <= rsp.res;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ design/nfa_seg_ram.sv @@
module nfa_seg_ram (
    input  logic                       clk,
    input  nfa_pkg::ram_wr_t           wr,
    input  logic [nfa_pkg::ADDR_W-1:0] rd_addr,
    output nfa_pkg::unit_t             rd_data
);

    // segment map: start and allocated marks per unit
    nfa_pkg::unit_t mem [nfa_pkg::HEAP_SIZE];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

@@ design/nfa_ctrl.sv @@
module nfa_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  nfa_pkg::cmd_t              cmd,
    output logic                       busy,
    output logic [nfa_pkg::ADDR_W-1:0] rd_addr,
    input  nfa_pkg::unit_t             rd_data,
    output nfa_pkg::ram_wr_t           wr,
    output nfa_pkg::rsp_t              rsp
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_WRA   = 3'd3;
    localparam logic [2:0] S_FCHK  = 3'd4;
    localparam logic [2:0] S_MERGE = 3'd5;

    logic [2:0]                        state_reg, state_next;
    logic [nfa_pkg::ADDR_W-1:0]        p_reg, p_next;
    logic [nfa_pkg::ADDR_W-1:0]        s_reg, s_next;
    logic [nfa_pkg::ADDR_W-1:0]        first_reg, first_next;
    logic [nfa_pkg::ADDR_W-1:0]        last_reg, last_next;
    logic [nfa_pkg::ADDR_W-1:0]        off_reg, off_next;
    logic [nfa_pkg::ADDR_W-1:0]        run_start_reg, run_start_next;
    logic [nfa_pkg::LEN_W-1:0]         len_reg, len_next;
    logic [nfa_pkg::SIZE_W-1:0]        size_reg, size_next;
    logic                              seg_free_reg, seg_free_next;
    logic                              started_reg, started_next;
    logic                              prev_free_reg, prev_free_next;

    logic [nfa_pkg::ADDR_W-1:0] p_inc;
    logic                       off_ok;
    logic                       pick;
    logic                       alloc_eff;

    assign p_inc  = (p_reg == nfa_pkg::LAST_ADDR) ? '0 : p_reg + 1'b1;
    assign off_ok = int'(cmd.free_offset) < nfa_pkg::HEAP_SIZE;
    assign pick   = started_reg && seg_free_reg &&
                    (nfa_pkg::CMP_W'(len_reg) == nfa_pkg::CMP_W'(size_reg));
    // the unit being freed reads as free during the merge sweep
    assign alloc_eff = rd_data.alloc_mark && (p_reg != off_reg);
    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        p_next         = p_reg;
        s_next         = s_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        off_next       = off_reg;
        run_start_next = run_start_reg;
        len_next       = len_reg;
        size_next      = size_reg;
        seg_free_next  = seg_free_reg;
        started_next   = started_reg;
        prev_free_next = prev_free_reg;
        rd_addr        = p_inc;
        wr             = '0;
        rsp            = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr.en              = 1'b1;
                wr.addr            = p_reg;
                wr.data.start_mark = (p_reg == '0);
                wr.data.alloc_mark = 1'b0;
                p_next             = p_inc;
                if (p_reg == nfa_pkg::LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd.opcode == nfa_pkg::OP_ALLOC)
                    begin
                        if (cmd.request_size == '0)
                        begin
                            rsp.valid      = 1'b1;
                            rsp.res.status = nfa_pkg::STATUS_ZERO;
                        end
                        else
                        begin
                            rd_addr      = last_reg;
                            p_next       = last_reg;
                            first_next   = last_reg;
                            size_next    = cmd.request_size;
                            started_next = 1'b0;
                            state_next   = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (off_ok)
                        begin
                            rd_addr    = nfa_pkg::ADDR_W'(cmd.free_offset);
                            off_next   = nfa_pkg::ADDR_W'(cmd.free_offset);
                            state_next = S_FCHK;
                        end
                        else
                        begin
                            rsp.valid      = 1'b1;
                            rsp.res.status = nfa_pkg::STATUS_BADFREE;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                p_next = p_inc;
                if (pick)
                begin
                    // segment fits; split off the remainder if it runs on
                    if (!rd_data.start_mark)
                    begin
                        wr.en              = 1'b1;
                        wr.addr            = p_reg;
                        wr.data.start_mark = 1'b1;
                        wr.data.alloc_mark = 1'b0;
                    end
                    state_next = S_WRA;
                end
                else if (rd_data.start_mark && started_reg && (p_reg == first_reg))
                begin
                    // full lap of the heap without a fit
                    rsp.valid      = 1'b1;
                    rsp.res.status = nfa_pkg::STATUS_NOFIT;
                    state_next     = S_IDLE;
                end
                else if (rd_data.start_mark)
                begin
                    s_next        = p_reg;
                    seg_free_next = !rd_data.alloc_mark;
                    len_next      = nfa_pkg::LEN_W'(1);
                    started_next  = 1'b1;
                end
                else
                begin
                    len_next = len_reg + 1'b1;
                end
            end
            S_WRA:
            begin
                wr.en                = 1'b1;
                wr.addr              = s_reg;
                wr.data.start_mark   = 1'b1;
                wr.data.alloc_mark   = 1'b1;
                last_next            = s_reg;
                rsp.valid            = 1'b1;
                rsp.res.status       = nfa_pkg::STATUS_OK;
                rsp.res.block_offset = nfa_pkg::OFF_W'(s_reg);
                state_next           = S_IDLE;
            end
            S_FCHK:
            begin
                if (!rd_data.start_mark)
                begin
                    rsp.valid      = 1'b1;
                    rsp.res.status = nfa_pkg::STATUS_BADFREE;
                    state_next     = S_IDLE;
                end
                else
                begin
                    rd_addr    = '0;
                    p_next     = '0;
                    state_next = S_MERGE;
                end
            end
            S_MERGE:
            begin
                // read of unit p+1 overlaps the write of unit p, never the same entry
                p_next  = p_inc;
                wr.en   = 1'b1;
                wr.addr = p_reg;
                if (p_reg == '0)
                begin
                    prev_free_next     = !alloc_eff;
                    run_start_next     = '0;
                    wr.data.start_mark = rd_data.start_mark;
                    wr.data.alloc_mark = alloc_eff;
                end
                else if (!rd_data.start_mark)
                begin
                    wr.data = rd_data;
                end
                else if (!alloc_eff && prev_free_reg)
                begin
                    // free segment after a free run: fold it in
                    wr.data = '0;
                    if (p_reg == last_reg)
                    begin
                        last_next = run_start_reg;
                    end
                end
                else
                begin
                    prev_free_next     = !alloc_eff;
                    run_start_next     = p_reg;
                    wr.data.start_mark = 1'b1;
                    wr.data.alloc_mark = alloc_eff;
                end
                if (p_reg == nfa_pkg::LAST_ADDR)
                begin
                    rsp.valid      = 1'b1;
                    rsp.res.status = nfa_pkg::STATUS_OK;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            p_reg         <= '0;
            last_reg      <= '0;
            started_reg   <= 1'b0;
            seg_free_reg  <= 1'b0;
            prev_free_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            p_reg         <= p_next;
            last_reg      <= last_next;
            started_reg   <= started_next;
            seg_free_reg  <= seg_free_next;
            prev_free_reg <= prev_free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg         <= s_next;
        first_reg     <= first_next;
        off_reg       <= off_next;
        run_start_reg <= run_start_next;
        len_reg       <= len_next;
        size_reg      <= size_next;
    end

endmodule

@@ design/nfa_checker.sv @@
module nfa_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input nfa_pkg::cmd_t    cmd,
    input logic             busy,
    input logic             done,
    input nfa_pkg::result_t result
);

    // failed results carry a zero offset
    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status != nfa_pkg::STATUS_OK) |-> result.block_offset == '0)
        else $error("non-zero offset on failed result");

    // zero-size allocate answers on the next cycle
    a_zero_size: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd.opcode == nfa_pkg::OP_ALLOC) && (cmd.request_size == '0)
        |=> done && (result.status == nfa_pkg::STATUS_ZERO))
        else $error("zero-size allocate not answered");

    // zero-size status comes only from a zero-size allocate
    a_zero_src: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == nfa_pkg::STATUS_ZERO)
        |-> $past(start && !busy && (cmd.opcode == nfa_pkg::OP_ALLOC)
                  && (cmd.request_size == '0)))
        else $error("zero-size status without zero-size allocate");

    // a sized allocate is not answered in the cycle after it is taken
    a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd.opcode == nfa_pkg::OP_ALLOC) && (cmd.request_size != '0)
        |=> busy && !done)
        else $error("sized allocate finished too early");

endmodule

bind next_fit_heap_allocator nfa_checker u_nfa_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
);
